>>> hw/rtl/cbtp_pkg.sv
// Shared types and constants of the colour bar test pattern generator.
package cbtp_pkg;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_DIM_W  = 13;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BARS_0       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BARS_4       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BARS_8       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BARS_12      = 3'd5;

	// Geometry limits and defaults
	localparam int WIDTH_MIN  = 16;
	localparam int HEIGHT_MIN = 1;
	localparam int WIDTH_RST  = 640;
	localparam int HEIGHT_RST = 480;

	// Band codes
	localparam logic [2:0] BAND_BARS  = 3'd0;
	localparam logic [2:0] BAND_RED   = 3'd1;
	localparam logic [2:0] BAND_GREEN = 3'd2;
	localparam logic [2:0] BAND_BLUE  = 3'd3;
	localparam logic [2:0] BAND_GRAY  = 3'd4;

	localparam logic [4:0] SEG_LAST = 5'd31;
	localparam logic [3:0] BAR_LAST = 4'd15;
	localparam logic [7:0] WHITE    = 8'hFF;

	// Sixteen RGB332 bar entries, entry i in element i
	typedef logic [15:0][7:0] bar_tbl_t;

	localparam bar_tbl_t BARS_RST = {32'hFF1FE303, 32'hFC1CE092, 32'hDB128202, 32'h90108000};

	// One result item
	typedef struct packed {
		logic [7:0] pixel;
		logic       end_of_line;
		logic       end_of_frame;
	} pix_res_t;

endpackage

>>> hw/rtl/cbtp_ifs.sv
// Channel interfaces: pixel request, pixel result and register write.
interface cbtp_in_if;
	logic valid;
	logic ready;
	logic restart;
	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface cbtp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;
	logic       end_of_line;
	logic       end_of_frame;
	modport source (output valid, output pixel, output end_of_line, output end_of_frame,
		input ready);
	modport sink (input valid, input pixel, input end_of_line, input end_of_frame,
		output ready);
endinterface

interface cbtp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cbtp_pkg::CFG_IDX_W-1:0]  index;
	logic [cbtp_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/cbtp_cfg.sv
// Register file: saturated frame geometry, band height and bar table.
module cbtp_cfg #(
	parameter int MAX_DIMENSION = 4096,
	localparam int DW = $clog2(MAX_DIMENSION + 1),
	localparam int LW = DW - 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	cbtp_cfg_if.sink             cfg,
	output logic [DW-1:0]        eff_w,
	output logic [DW-1:0]        eff_h,
	output logic [LW-1:0]        h5,
	output cbtp_pkg::bar_tbl_t   bars
);

	localparam int W_RST   = (cbtp_pkg::WIDTH_RST > MAX_DIMENSION) ?
		MAX_DIMENSION : cbtp_pkg::WIDTH_RST;
	localparam int H_RST   = (cbtp_pkg::HEIGHT_RST > MAX_DIMENSION) ?
		MAX_DIMENSION : cbtp_pkg::HEIGHT_RST;
	localparam int H5_RST  = H_RST / 5;
	// Reciprocal of five, exact for every DW-bit height
	localparam int RECIP_SH = DW + 3;
	localparam logic [DW:0] RECIP = (DW + 1)'(((1 << RECIP_SH) + 4) / 5);

	logic [DW-1:0]          w_q, h_q;
	logic [LW-1:0]          h5_q;
	cbtp_pkg::bar_tbl_t     bars_q;
	logic [31:0]            raw;
	logic [31:0]            w_sat, h_sat;
	logic [DW-1:0]          h_new;
	logic [2*DW:0]          h_prod;

	assign cfg.ready = 1'b1;

	// Saturate the written dimension and divide the height by five
	always_comb begin
		raw = 32'(cfg.data[cbtp_pkg::CFG_DIM_W-1:0]);
		if (raw < 32'(cbtp_pkg::WIDTH_MIN))
			w_sat = 32'(cbtp_pkg::WIDTH_MIN);
		else if (raw > 32'(MAX_DIMENSION))
			w_sat = 32'(MAX_DIMENSION);
		else
			w_sat = raw;
		if (raw < 32'(cbtp_pkg::HEIGHT_MIN))
			h_sat = 32'(cbtp_pkg::HEIGHT_MIN);
		else if (raw > 32'(MAX_DIMENSION))
			h_sat = 32'(MAX_DIMENSION);
		else
			h_sat = raw;
		h_new  = h_sat[DW-1:0];
		h_prod = (2*DW+1)'(h_new) * (2*DW+1)'(RECIP);
	end

	// Take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= DW'(W_RST);
			h_q    <= DW'(H_RST);
			h5_q   <= LW'(H5_RST);
			bars_q <= cbtp_pkg::BARS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				cbtp_pkg::REG_FRAME_WIDTH: begin
					w_q <= w_sat[DW-1:0];
				end
				cbtp_pkg::REG_FRAME_HEIGHT: begin
					h_q  <= h_new;
					h5_q <= h_prod[RECIP_SH +: LW];
				end
				cbtp_pkg::REG_BARS_0:  bars_q[0 +: 4]  <= cfg.data;
				cbtp_pkg::REG_BARS_4:  bars_q[4 +: 4]  <= cfg.data;
				cbtp_pkg::REG_BARS_8:  bars_q[8 +: 4]  <= cfg.data;
				cbtp_pkg::REG_BARS_12: bars_q[12 +: 4] <= cfg.data;
				default: ;
			endcase
		end
	end

	assign eff_w = w_q;
	assign eff_h = h_q;
	assign h5    = h5_q;
	assign bars  = bars_q;

endmodule

>>> hw/rtl/cbtp_raster.sv
// Raster position, band and segment counters with the pixel colour logic.
module cbtp_raster #(
	parameter int MAX_DIMENSION = 4096,
	localparam int DW = $clog2(MAX_DIMENSION + 1),
	localparam int LW = DW - 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 restart,
	input  logic [DW-1:0]        eff_w,
	input  logic [DW-1:0]        eff_h,
	input  logic [LW-1:0]        h5,
	input  cbtp_pkg::bar_tbl_t   bars,
	output cbtp_pkg::pix_res_t   res
);

	localparam int PW       = $clog2(MAX_DIMENSION);
	localparam int W_RST    = (cbtp_pkg::WIDTH_RST > MAX_DIMENSION) ?
		MAX_DIMENSION : cbtp_pkg::WIDTH_RST;
	localparam int LEFT_RST = W_RST / 16;

	logic [PW-1:0] col_q, row_q;
	logic [2:0]    band_q;
	logic [4:0]    seg_q;
	logic [LW-1:0] left_q;

	logic [PW-1:0] col_c, row_c, col_n, row_n, row_inc;
	logic [2:0]    band_c, band_n, fs_band, first_open, line_band;
	logic [4:0]    seg_c, seg_n;
	logic [LW-1:0] left_c, left_n;
	logic [DW-1:0] bend1, bend2, bend3, bend4, row_inc_x;
	logic          eol, eof, last_row, border;

	function automatic logic [LW-1:0] seg_len(input logic [2:0] b, input logic [DW-1:0] w);
		case (b)
			cbtp_pkg::BAND_BARS: return LW'(w >> 4);
			cbtp_pkg::BAND_BLUE: return w[DW-1:2];
			default:             return LW'(w >> 3);
		endcase
	endfunction

	function automatic logic [7:0] band_color(input logic [2:0] b, input logic [4:0] s,
		input cbtp_pkg::bar_tbl_t tbl);
		logic [3:0] idx;
		idx = (s > 5'(cbtp_pkg::BAR_LAST)) ? cbtp_pkg::BAR_LAST : s[3:0];
		case (b)
			cbtp_pkg::BAND_BARS:  return tbl[idx];
			cbtp_pkg::BAND_RED:   return {s[2:0], 5'b0};
			cbtp_pkg::BAND_GREEN: return {1'b0, s, 2'b0};
			cbtp_pkg::BAND_BLUE:  return {3'b0, s};
			default:              return {s[2:0], 5'b0} | {1'b0, s, 2'b0} | {4'b0, s[4:1]};
		endcase
	endfunction

	// Band end rows; an empty first band means every band but the last is empty
	always_comb begin
		bend1   = DW'(h5);
		bend2   = bend1 << 1;
		bend3   = bend1 + bend2;
		bend4   = bend1 << 2;
		fs_band = (h5 == '0) ? cbtp_pkg::BAND_GRAY : cbtp_pkg::BAND_BARS;
	end

	// Current position, with restart forcing the top-left pixel
	always_comb begin
		if (restart) begin
			col_c  = '0;
			row_c  = '0;
			band_c = fs_band;
			seg_c  = '0;
			left_c = seg_len(fs_band, eff_w);
		end else begin
			col_c  = col_q;
			row_c  = row_q;
			band_c = band_q;
			seg_c  = seg_q;
			left_c = left_q;
		end
	end

	// Colour and line/frame markers
	always_comb begin
		eol      = DW'(col_c) >= (eff_w - DW'(1));
		last_row = DW'(row_c) >= (eff_h - DW'(1));
		eof      = eol && last_row;
		border   = (col_c == '0) || eol || (row_c == '0) || last_row;
		res.pixel        = border ? cbtp_pkg::WHITE : band_color(band_c, seg_c, bars);
		res.end_of_line  = eol;
		res.end_of_frame = eof;
	end

	// Advance the raster
	always_comb begin
		row_inc    = row_c + PW'(1);
		row_inc_x  = DW'(row_inc);
		first_open = 3'(row_inc_x >= bend1) + 3'(row_inc_x >= bend2) +
			3'(row_inc_x >= bend3) + 3'(row_inc_x >= bend4);
		line_band  = (first_open > band_c) ? first_open : band_c;
		col_n  = col_c + PW'(1);
		row_n  = row_c;
		band_n = band_c;
		seg_n  = seg_c;
		left_n = left_c - LW'(1);
		if (eol) begin
			col_n = '0;
			seg_n = '0;
			if (eof) begin
				row_n  = '0;
				band_n = fs_band;
			end else begin
				row_n  = row_inc;
				band_n = line_band;
			end
			left_n = seg_len(band_n, eff_w);
		end else if (left_c <= LW'(1)) begin
			left_n = seg_len(band_c, eff_w);
			if (seg_c < cbtp_pkg::SEG_LAST)
				seg_n = seg_c + 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			band_q <= cbtp_pkg::BAND_BARS;
			seg_q  <= '0;
			left_q <= LW'(LEFT_RST);
		end else if (step) begin
			col_q  <= col_n;
			row_q  <= row_n;
			band_q <= band_n;
			seg_q  <= seg_n;
			left_q <= left_n;
		end
	end

endmodule

>>> hw/rtl/color_bar_test_pattern_generator_top.sv
// A taken request waits in the request stage and moves into the result register once that is free.
// Throughput: one pixel per cycle while the result side keeps taking pixels.
// A new request is taken while a finished pixel still waits at the output.
// Reset clears both stage valids, points the raster at pixel (0,0) of band 0
// and loads 640x480 geometry (clamped to MAX_DIMENSION) with the default bar table.
module color_bar_test_pattern_generator_top #(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	cbtp_cfg_if.sink    cfg,
	cbtp_in_if.sink     pix_in,
	cbtp_out_if.source  pix_out
);

	localparam int DW = $clog2(MAX_DIMENSION + 1);
	localparam int LW = DW - 2;

	logic                 vld_s1, restart_s1, vld_s2, adv;
	cbtp_pkg::pix_res_t   res, res_s2;
	logic [DW-1:0]        eff_w, eff_h;
	logic [LW-1:0]        h5;
	cbtp_pkg::bar_tbl_t   bars;

	cbtp_cfg #(.MAX_DIMENSION(MAX_DIMENSION)) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.eff_w  (eff_w),
		.eff_h  (eff_h),
		.h5     (h5),
		.bars   (bars)
	);

	cbtp_raster #(.MAX_DIMENSION(MAX_DIMENSION)) u_raster (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.restart (restart_s1),
		.eff_w   (eff_w),
		.eff_h   (eff_h),
		.h5      (h5),
		.bars    (bars),
		.res     (res)
	);

	// Move the held request into the result register when it is free
	assign adv          = vld_s1 && (!vld_s2 || pix_out.ready);
	assign pix_in.ready = !vld_s1 || adv;

	// Hold the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pix_in.valid && pix_in.ready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_in.valid && pix_in.ready)
			restart_s1 <= pix_in.restart;
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (pix_out.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res;
	end

	assign pix_out.valid        = vld_s2;
	assign pix_out.pixel        = res_s2.pixel;
	assign pix_out.end_of_line  = res_s2.end_of_line;
	assign pix_out.end_of_frame = res_s2.end_of_frame;

`ifndef SYNTHESIS
	a_eof_on_eol: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (!res_s2.end_of_frame || res_s2.end_of_line))
		else $error("end of frame without end of line");

	a_req_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv) |=> vld_s1)
		else $error("held request lost");

	a_restart_white: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && restart_s1) |=> (vld_s2 && res_s2.pixel == cbtp_pkg::WHITE))
		else $error("restart pixel is not border white");
`endif

endmodule

>>> bench/tb_color_bar_test_pattern_generator_top.sv
// Self-checking bench for the colour bar test pattern generator: raster, bands, border, clamps.
module tb_color_bar_test_pattern_generator_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIM         = 4096;
	localparam int RANDOM_REQUESTS = 400;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int REPORT_LIMIT    = 10;
	localparam int HI_W            = cbtp_pkg::CFG_DATA_W - cbtp_pkg::CFG_DIM_W;

	// Indexes past the register list; writes to them must change nothing
	localparam logic [cbtp_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [cbtp_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam logic [cbtp_pkg::CFG_IDX_W-1:0] BAR_REGS [4] = '{cbtp_pkg::REG_BARS_0,
		cbtp_pkg::REG_BARS_4, cbtp_pkg::REG_BARS_8, cbtp_pkg::REG_BARS_12};

	typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_LIGHT, RX_SLOW} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	cbtp_cfg_if reg_ch ();
	cbtp_in_if  req_ch ();
	cbtp_out_if res_ch ();

	color_bar_test_pattern_generator_top #(
		.MAX_DIMENSION(MAX_DIM)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (reg_ch),
		.pix_in  (req_ch),
		.pix_out (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the registers and raster state
	logic [cbtp_pkg::CFG_DIM_W-1:0] model_width_reg;
	logic [cbtp_pkg::CFG_DIM_W-1:0] model_height_reg;
	logic [31:0]          model_bars [4];
	logic [11:0]          col_pos;
	logic [11:0]          row_pos;
	logic [2:0]           cur_band;
	logic [12:0]          cur_band_end;
	logic [4:0]           seg_idx;
	logic [11:0]          seg_left;

	cbtp_pkg::pix_res_t pending_pixels [$];
	int       mismatch_count = 0;
	int       cycle_count    = 0;
	int       burst_left     = 0;
	int       stall_left     = 0;
	rx_mode_t stall_mode     = RX_FLOW;

	function automatic int unsigned clamped_width();
		int unsigned w;
		w = model_width_reg;
		if (w < cbtp_pkg::WIDTH_MIN) w = cbtp_pkg::WIDTH_MIN;
		if (w > MAX_DIM) w = MAX_DIM;
		return w;
	endfunction

	function automatic int unsigned clamped_height();
		int unsigned h;
		h = model_height_reg;
		if (h < cbtp_pkg::HEIGHT_MIN) h = cbtp_pkg::HEIGHT_MIN;
		if (h > MAX_DIM) h = MAX_DIM;
		return h;
	endfunction

	function automatic int unsigned band_end_of(input logic [2:0] k);
		int unsigned h;
		h = clamped_height();
		if (k >= cbtp_pkg::BAND_GRAY) return h;
		return (int'(k) + 1) * (h / 5);
	endfunction

	function automatic int unsigned segment_length(input logic [2:0] k);
		int unsigned w;
		w = clamped_width();
		if (k == cbtp_pkg::BAND_BARS) return w / 16;
		if (k == cbtp_pkg::BAND_BLUE) return w / 4;
		return w / 8;
	endfunction

	// Skip past bands whose end row is already behind, then reload the segment
	function automatic void begin_line();
		while (cur_band < cbtp_pkg::BAND_GRAY && row_pos >= band_end_of(cur_band))
			cur_band = cur_band + 3'd1;
		cur_band_end = 13'(band_end_of(cur_band));
		seg_idx      = '0;
		seg_left     = 12'(segment_length(cur_band));
	endfunction

	function automatic void begin_frame();
		col_pos  = '0;
		row_pos  = '0;
		cur_band = cbtp_pkg::BAND_BARS;
		begin_line();
	endfunction

	function automatic logic [7:0] band_colour();
		int unsigned s;
		logic [3:0]  idx;
		s = seg_idx;
		case (cur_band)
			cbtp_pkg::BAND_BARS: begin
				idx = (seg_idx > 5'(cbtp_pkg::BAR_LAST)) ? cbtp_pkg::BAR_LAST : seg_idx[3:0];
				return model_bars[idx[3:2]][idx[1:0]*8 +: 8];
			end
			cbtp_pkg::BAND_RED:   return 8'(s << 5);
			cbtp_pkg::BAND_GREEN: return 8'(s << 2);
			cbtp_pkg::BAND_BLUE:  return 8'(s);
			default:              return 8'((s << 5) | (s << 2) | (s >> 1));
		endcase
	endfunction

	// Work out the pixel one request yields and advance the raster
	function automatic cbtp_pkg::pix_res_t predict_pixel(input logic restart_bit);
		int unsigned        w;
		int unsigned        h;
		logic               eol;
		logic               eof;
		cbtp_pkg::pix_res_t res;
		if (restart_bit) begin_frame();
		w   = clamped_width();
		h   = clamped_height();
		eol = (col_pos >= w - 1);
		eof = eol && (row_pos >= h - 1);
		if (col_pos == 0 || eol || row_pos == 0 || row_pos >= h - 1)
			res.pixel = cbtp_pkg::WHITE;
		else
			res.pixel = band_colour();
		res.end_of_line  = eol;
		res.end_of_frame = eof;
		if (eol) begin
			col_pos = '0;
			if (eof) begin
				begin_frame();
			end else begin
				row_pos = row_pos + 12'd1;
				begin_line();
			end
		end else begin
			col_pos = col_pos + 12'd1;
			if (seg_left <= 1) begin
				seg_left = 12'(segment_length(cur_band));
				if (seg_idx < cbtp_pkg::SEG_LAST) seg_idx = seg_idx + 5'd1;
			end else begin
				seg_left = seg_left - 12'd1;
			end
		end
		return res;
	endfunction

	function automatic void apply_reg(input logic [cbtp_pkg::CFG_IDX_W-1:0] idx,
		input logic [cbtp_pkg::CFG_DATA_W-1:0] value);
		case (idx)
			cbtp_pkg::REG_FRAME_WIDTH:  model_width_reg  = value[cbtp_pkg::CFG_DIM_W-1:0];
			cbtp_pkg::REG_FRAME_HEIGHT: model_height_reg = value[cbtp_pkg::CFG_DIM_W-1:0];
			cbtp_pkg::REG_BARS_0:       model_bars[0]    = value;
			cbtp_pkg::REG_BARS_4:       model_bars[1]    = value;
			cbtp_pkg::REG_BARS_8:       model_bars[2]    = value;
			cbtp_pkg::REG_BARS_12:      model_bars[3]    = value;
			default: ;
		endcase
	endfunction

	// Mostly small frames so lines and frames wrap often; clamp cases now and then
	function automatic logic [cbtp_pkg::CFG_DATA_W-1:0] pick_width();
		logic [cbtp_pkg::CFG_DATA_W-1:0] w;
		case ($urandom_range(0, 11))
			0:       w = $urandom_range(0, 15);
			1:       w = $urandom_range(4096, 8191);
			2:       w = 8191;
			3:       w = $urandom_range(4095, 4097);
			default: w = $urandom_range(16, 40);
		endcase
		// Upper data bits fall outside the register
		if ($urandom_range(0, 7) == 0)
			w[cbtp_pkg::CFG_DATA_W-1:cbtp_pkg::CFG_DIM_W] = HI_W'($urandom());
		return w;
	endfunction

	function automatic logic [cbtp_pkg::CFG_DATA_W-1:0] pick_height();
		logic [cbtp_pkg::CFG_DATA_W-1:0] h;
		case ($urandom_range(0, 11))
			0:       h = $urandom_range(0, 1);
			1:       h = $urandom_range(4096, 8191);
			2:       h = $urandom_range(2, 4);
			default: h = $urandom_range(5, 14);
		endcase
		if ($urandom_range(0, 7) == 0)
			h[cbtp_pkg::CFG_DATA_W-1:cbtp_pkg::CFG_DIM_W] = HI_W'($urandom());
		return h;
	endfunction

	function automatic logic [cbtp_pkg::CFG_DATA_W-1:0] pick_bars();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return $urandom();
		endcase
	endfunction

	// Send one request; hold valid across a burst, drop it for a random gap after
	task automatic send_request(input logic restart_bit);
		int gap;
		req_ch.valid   <= 1'b1;
		req_ch.restart <= restart_bit;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pending_pixels.push_back(predict_pixel(restart_bit));
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
				: $urandom_range(0, 12);
		end
	endtask

	// Stop requesting and wait until every predicted pixel has come back
	task automatic drain_requests();
		req_ch.valid <= 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [cbtp_pkg::CFG_IDX_W-1:0] idx,
		input logic [cbtp_pkg::CFG_DATA_W-1:0] value);
		reg_ch.valid <= 1'b1;
		reg_ch.index <= idx;
		reg_ch.data  <= value;
		@(posedge clk);
		while (!reg_ch.ready) @(posedge clk);
		apply_reg(idx, value);
		@(negedge clk);
		reg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Default geometry straight out of reset, with a restart in the middle
	task automatic test_reset_defaults();
		send_request(1'b0);
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
		drain_requests();
	endtask

	// Geometry beyond both ends of its range, and writes to spare indexes
	task automatic test_clamped_geometry();
		write_reg(cbtp_pkg::REG_FRAME_WIDTH, 32'd8191);
		write_reg(cbtp_pkg::REG_FRAME_HEIGHT, 32'd8191);
		write_reg(REG_SPARE_6, $urandom());
		write_reg(REG_SPARE_7, $urandom());
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b0);
		drain_requests();
		write_reg(cbtp_pkg::REG_FRAME_WIDTH, 32'd0);
		write_reg(cbtp_pkg::REG_FRAME_HEIGHT, 32'd0);
		send_request(1'b1);
		repeat (16) send_request(1'b0);
		drain_requests();
	endtask

	// Phases of random geometry and bar tables; state carries over between them
	task automatic test_random_frames();
		int sent;
		int n;
		sent = 0;
		foreach (BAR_REGS[i]) write_reg(BAR_REGS[i], pick_bars());
		while (sent < RANDOM_REQUESTS) begin
			if ($urandom_range(0, 3) != 0) begin
				write_reg(cbtp_pkg::REG_FRAME_WIDTH, pick_width());
				write_reg(cbtp_pkg::REG_FRAME_HEIGHT, pick_height());
			end
			if ($urandom_range(0, 2) == 0)
				write_reg(BAR_REGS[$urandom_range(0, 3)], pick_bars());
			n = $urandom_range(20, 70);
			for (int i = 0; i < n; i++)
				send_request(i == 0 ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 39) == 0));
			sent += n;
			drain_requests();
		end
	endtask

	// Result side stalls on a random pattern, redrawn each time its countdown runs out
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = rx_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(8, 64);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			RX_FLOW:  res_ch.ready <= 1'b1;
			RX_COIN:  res_ch.ready <= 1'($urandom_range(0, 1));
			RX_LIGHT: res_ch.ready <= ($urandom_range(0, 7) != 0);
			default:  res_ch.ready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	// Compare each accepted pixel with the oldest prediction
	always @(posedge clk) begin
		cbtp_pkg::pix_res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_pixels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected pixel %02h eol %b eof %b at cycle %0d",
						res_ch.pixel, res_ch.end_of_line, res_ch.end_of_frame, cycle_count);
			end else begin
				want = pending_pixels.pop_front();
				if (res_ch.pixel !== want.pixel || res_ch.end_of_line !== want.end_of_line
						|| res_ch.end_of_frame !== want.end_of_frame) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("pixel mismatch at cycle %0d: expected %02h/%b/%b got %02h/%b/%b",
							cycle_count, want.pixel, want.end_of_line, want.end_of_frame,
							res_ch.pixel, res_ch.end_of_line, res_ch.end_of_frame);
				end
			end
		end
	end

	// Guard against a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** color_bar_test_pattern_generator_top: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.restart = 1'b0;
		reg_ch.valid   = 1'b0;
		reg_ch.index   = cbtp_pkg::REG_FRAME_WIDTH;
		reg_ch.data    = '0;
		model_width_reg  = cbtp_pkg::CFG_DIM_W'(cbtp_pkg::WIDTH_RST);
		model_height_reg = cbtp_pkg::CFG_DIM_W'(cbtp_pkg::HEIGHT_RST);
		for (int i = 0; i < 4; i++) model_bars[i] = cbtp_pkg::BARS_RST[i*4 +: 4];
		begin_frame();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_clamped_geometry();
		test_random_frames();

		drain_requests();
		repeat (4) @(negedge clk);
		if (mismatch_count == 0)
			$display("** color_bar_test_pattern_generator_top: PASSED **");
		else
			$display("** color_bar_test_pattern_generator_top: FAILED **");
		$finish;
	end

endmodule
